[rtl/ang_pkg.sv]
// ---------------------------------------------------------------------------
// Audio noise gate packetizer package
// Shared types, register indexes and constants of the noise gate packetizer.
// ---------------------------------------------------------------------------
package ang_pkg;

   localparam int MAX_HEADER_BYTES = 8;
   localparam int MAX_PACKET_BYTES = 4096;

   localparam int SAMPLE_W  = 16;
   localparam int THRESH_W  = 16;
   localparam int HOLD_W    = 16;
   localparam int PKT_W     = 13;
   localparam int HLEN_W    = 4;
   localparam int HBYTES_W  = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int HIDX_W    = $clog2(MAX_HEADER_BYTES + 1);
   localparam int HSEL_W    = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;

   localparam logic [THRESH_W-1:0] OPEN_THRESHOLD_RESET  = THRESH_W'(520);
   localparam logic [THRESH_W-1:0] CLOSE_THRESHOLD_RESET = THRESH_W'(360);
   localparam logic [HOLD_W-1:0]   HOLD_SAMPLES_RESET    = HOLD_W'(192);
   localparam logic [PKT_W-1:0]    PACKET_BYTES_RESET    = PKT_W'(1024);
   localparam logic [PKT_W-1:0]    PACKET_BYTES_MIN      = PKT_W'(2);
   localparam logic [PKT_W-1:0]    PACKET_BYTES_MAX      = PKT_W'(MAX_PACKET_BYTES);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OPEN_THRESHOLD  = 3'd0,
      REG_CLOSE_THRESHOLD = 3'd1,
      REG_HOLD_SAMPLES    = 3'd2,
      REG_PACKET_BYTES    = 3'd3,
      REG_HEADER_LENGTH   = 3'd4,
      REG_HEADER_BYTES    = 3'd5
   } reg_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_FLUSH  = 1'b1
   } command_type;

   typedef struct packed {
      logic [THRESH_W-1:0] open_threshold;
      logic [THRESH_W-1:0] close_threshold;
      logic [HOLD_W-1:0]   hold_samples;
      logic [PKT_W-1:0]    packet_bytes;
      logic [HLEN_W-1:0]   header_length;
      logic [HBYTES_W-1:0] header_bytes;
   } cfg_type;

endpackage

[rtl/ang_req_if.sv]
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one command and one audio sample.
// ---------------------------------------------------------------------------
interface ang_req_if;
   import ang_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

[rtl/ang_rsp_if.sv]
// ---------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one output byte with its framing flags.
// ---------------------------------------------------------------------------
interface ang_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       packet_last;

   modport source (output valid, output out_byte, output byte_valid, output packet_last,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input packet_last,
                   output ready);
endinterface

[rtl/ang_csr.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// Write-only register file holding thresholds, hold time and framing setup.
// ---------------------------------------------------------------------------
module ang_csr
   import ang_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_threshold  <= OPEN_THRESHOLD_RESET;
         cfg_ff.close_threshold <= CLOSE_THRESHOLD_RESET;
         cfg_ff.hold_samples    <= HOLD_SAMPLES_RESET;
         cfg_ff.packet_bytes    <= PACKET_BYTES_RESET;
         cfg_ff.header_length   <= '0;
         cfg_ff.header_bytes    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_OPEN_THRESHOLD:  cfg_ff.open_threshold  <= csr_wdata[THRESH_W-1:0];
            REG_CLOSE_THRESHOLD: cfg_ff.close_threshold <= csr_wdata[THRESH_W-1:0];
            REG_HOLD_SAMPLES:    cfg_ff.hold_samples    <= csr_wdata[HOLD_W-1:0];
            REG_PACKET_BYTES:    cfg_ff.packet_bytes    <= csr_wdata[PKT_W-1:0];
            REG_HEADER_LENGTH:   cfg_ff.header_length   <= csr_wdata[HLEN_W-1:0];
            REG_HEADER_BYTES:    cfg_ff.header_bytes    <= csr_wdata[HBYTES_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ang_gate.sv]
// ---------------------------------------------------------------------------
// Noise gate and byte converter
// Hysteresis gate with hold counter, followed by 16-to-8-bit conversion.
// ---------------------------------------------------------------------------
module ang_gate
   import ang_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       sample_accept,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  cfg_type                    cfg,
   output logic [7:0]                 gated_byte
);

   logic              open_state_ff, open_state_in;
   logic [HOLD_W-1:0] hold_count_ff, hold_count_in;
   logic [SAMPLE_W:0] level;
   logic signed [SAMPLE_W-1:0] gated;
   logic signed [SAMPLE_W-4:0] scaled;
   logic signed [7:0]          clamped;

   // Magnitude of a signed 16-bit value fits in 17 bits (covers -32768).
   assign level = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                     : {1'b0, sample};

   always_comb begin
      open_state_in = open_state_ff;
      hold_count_in = hold_count_ff;
      if (open_state_ff) begin
         if (level < {1'b0, cfg.close_threshold}) begin
            if (hold_count_ff != '0) begin
               hold_count_in = hold_count_ff - HOLD_W'(1);
            end else begin
               open_state_in = 1'b0;
            end
         end else begin
            hold_count_in = cfg.hold_samples;
         end
      end else if (level > {1'b0, cfg.open_threshold}) begin
         open_state_in = 1'b1;
         hold_count_in = cfg.hold_samples;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_state_ff <= 1'b0;
         hold_count_ff <= '0;
      end else if (sample_accept) begin
         open_state_ff <= open_state_in;
         hold_count_ff <= hold_count_in;
      end
   end

   // Arithmetic shift rounds toward minus infinity, then clamp and offset.
   always_comb begin
      gated  = open_state_in ? sample : '0;
      scaled = gated[SAMPLE_W-1:3];
      if (scaled < -(SAMPLE_W-3)'(128)) begin
         clamped = -8'sd128;
      end else if (scaled > (SAMPLE_W-3)'(127)) begin
         clamped = 8'sd127;
      end else begin
         clamped = scaled[7:0];
      end
      gated_byte = {~clamped[7], clamped[6:0]};
   end

endmodule

[rtl/ang_framer.sv]
// ---------------------------------------------------------------------------
// Packet framer
// Tracks packet fill, holds one pending transaction and drains its header
// and data bytes through the output register.
// ---------------------------------------------------------------------------
module ang_framer
   import ang_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   input  logic       req_command,
   input  logic [7:0] gated_byte,
   output logic       req_ready,
   output logic       sample_accept,
   ang_rsp_if.source  rsp_bus
);

   logic [PKT_W-1:0]  pkt_eff;
   logic [HIDX_W-1:0] hdr_clip;
   logic [HIDX_W-1:0] hdr_eff;
   logic [PKT_W-1:0]  payload_count_ff, payload_count_in;
   logic [PKT_W:0]    fill_sum;
   logic              pkt_done;

   logic              job_valid_ff, job_valid_in;
   logic [HIDX_W-1:0] job_hdr_left_ff, job_hdr_left_in;
   logic [HSEL_W-1:0] job_hdr_idx_ff, job_hdr_idx_in;
   logic [7:0]        job_byte_ff, job_byte_in;
   logic              job_data_ff, job_data_in;
   logic              job_last_ff, job_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic slot_free, move, job_final, accept, is_flush;

   // Effective packet size and header length.
   always_comb begin
      if (cfg.packet_bytes < PACKET_BYTES_MIN) begin
         pkt_eff = PACKET_BYTES_MIN;
      end else if (cfg.packet_bytes > PACKET_BYTES_MAX) begin
         pkt_eff = PACKET_BYTES_MAX;
      end else begin
         pkt_eff = cfg.packet_bytes;
      end
      if ({1'b0, cfg.header_length} > (HLEN_W+1)'(MAX_HEADER_BYTES)) begin
         hdr_clip = HIDX_W'(MAX_HEADER_BYTES);
      end else begin
         hdr_clip = HIDX_W'(cfg.header_length);
      end
      hdr_eff = (PKT_W'(hdr_clip) >= pkt_eff) ? '0 : hdr_clip;
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign move      = job_valid_ff && slot_free;
   assign job_final = (job_hdr_left_ff == '0);
   assign req_ready = !job_valid_ff || (move && job_final);
   assign accept    = req_valid && req_ready;
   assign is_flush  = (req_command == CMD_FLUSH);
   assign sample_accept = accept && !is_flush;

   assign fill_sum = {1'b0, payload_count_ff} + (PKT_W+1)'(1) + (PKT_W+1)'(hdr_eff);
   assign pkt_done = (fill_sum >= {1'b0, pkt_eff});

   // Packet fill and pending transaction.
   always_comb begin
      payload_count_in = payload_count_ff;
      job_valid_in     = job_valid_ff;
      job_hdr_left_in  = job_hdr_left_ff;
      job_hdr_idx_in   = job_hdr_idx_ff;
      job_byte_in      = job_byte_ff;
      job_data_in      = job_data_ff;
      job_last_in      = job_last_ff;
      if (move) begin
         if (job_final) begin
            job_valid_in = 1'b0;
         end else begin
            job_hdr_left_in = job_hdr_left_ff - HIDX_W'(1);
            job_hdr_idx_in  = job_hdr_idx_ff + HSEL_W'(1);
         end
      end
      if (accept) begin
         if (is_flush) begin
            // A flush of an empty packet produces nothing.
            if (payload_count_ff != '0) begin
               job_valid_in    = 1'b1;
               job_hdr_left_in = '0;
               job_hdr_idx_in  = '0;
               job_byte_in     = '0;
               job_data_in     = 1'b0;
               job_last_in     = 1'b1;
            end
            payload_count_in = '0;
         end else begin
            job_valid_in    = 1'b1;
            job_hdr_left_in = (payload_count_ff == '0) ? hdr_eff : '0;
            job_hdr_idx_in  = '0;
            job_byte_in     = gated_byte;
            job_data_in     = 1'b1;
            job_last_in     = pkt_done;
            payload_count_in = pkt_done ? '0 : payload_count_ff + PKT_W'(1);
         end
      end
   end

   // Output register: header bytes first, then the data byte or end marker.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         if (job_final) begin
            rsp_byte_in = job_byte_ff;
            rsp_data_in = job_data_ff;
            rsp_last_in = job_last_ff;
         end else begin
            rsp_byte_in = cfg.header_bytes[8*job_hdr_idx_ff +: 8];
            rsp_data_in = 1'b1;
            rsp_last_in = 1'b0;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_count_ff <= '0;
         job_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         payload_count_ff <= payload_count_in;
         job_valid_ff     <= job_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_hdr_left_ff <= job_hdr_left_in;
      job_hdr_idx_ff  <= job_hdr_idx_in;
      job_byte_ff     <= job_byte_in;
      job_data_ff     <= job_data_in;
      job_last_ff     <= job_last_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_byte    = rsp_byte_ff;
   assign rsp_bus.byte_valid  = rsp_data_ff;
   assign rsp_bus.packet_last = rsp_last_ff;

endmodule

[rtl/audio_noise_gate_packetizer.sv]
// ---------------------------------------------------------------------------
// Audio noise gate packetizer
// Noise gate with hysteresis and hold, 8-bit conversion and byte framing.
// ---------------------------------------------------------------------------
// Each request transaction carries a command and a signed 16-bit sample. A
// sample passes the noise gate, is reduced to an offset-binary byte and is
// sent as one response transaction; the first sample of a packet is preceded
// by the configured header bytes, and the byte that fills a packet carries
// packet_last. A flush of a partial packet sends one end marker (byte_valid
// low, packet_last high); a flush of an empty packet sends nothing. One
// sample is taken per clock cycle in steady state while the response
// channel is ready. All bytes leave through a single output register at
// one byte per cycle; the next request is held off while header bytes
// drain. Gate and conversion logic run in the cycle of acceptance. The
// user must write configuration registers only while the block is idle;
// the block itself does not enforce this.
// ---------------------------------------------------------------------------
module audio_noise_gate_packetizer
   import ang_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ang_req_if.sink               req_bus,
   ang_rsp_if.source             rsp_bus
);

   cfg_type    cfg;
   logic [7:0] gated_byte;
   logic       sample_accept;

   // Configuration register file.
   ang_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // The gate state advances only on accepted sample transactions.
   ang_gate u_gate (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (sample_accept),
      .sample        (req_bus.sample),
      .cfg           (cfg),
      .gated_byte    (gated_byte)
   );

   // The framer owns the handshake on both channels.
   ang_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_bus.valid),
      .req_command   (req_bus.command),
      .gated_byte    (gated_byte),
      .req_ready     (req_bus.ready),
      .sample_accept (sample_accept),
      .rsp_bus       (rsp_bus)
   );

endmodule
